/* design/assert_macros.svh */
// Assertion macros for the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DLPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dlpe assertion failed");

// Clocked assertion that also holds during reset.
`define DLPE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dlpe reset assertion failed");

`endif

/* design/dlpe_pkg.sv */
// Package for the line program engine: operation codes, queue entry and
// configuration types. No dependencies.
`timescale 1ns / 1ps
package dlpe_pkg;

  localparam int AddrW = 64;
  localparam int RegW  = 32;
  localparam logic [7:0] OpcMax = 8'd255;

  localparam logic [2:0] CFG_OP_BASE     = 3'd0;
  localparam logic [2:0] CFG_LN_RANGE    = 3'd1;
  localparam logic [2:0] CFG_LN_BASE     = 3'd2;
  localparam logic [2:0] CFG_MIN_INST    = 3'd3;
  localparam logic [2:0] CFG_MAX_OPS     = 3'd4;
  localparam logic [2:0] CFG_ADDR_64     = 3'd5;

  localparam logic [7:0] LNS_COPY        = 8'd1;
  localparam logic [7:0] LNS_ADVANCE_PC  = 8'd2;
  localparam logic [7:0] LNS_ADVANCE_LN  = 8'd3;
  localparam logic [7:0] LNS_SET_FILE    = 8'd4;
  localparam logic [7:0] LNS_SET_COLUMN  = 8'd5;
  localparam logic [7:0] LNS_NEGATE_STMT = 8'd6;
  localparam logic [7:0] LNS_BASIC_BLOCK = 8'd7;
  localparam logic [7:0] LNS_CONST_ADD   = 8'd8;
  localparam logic [7:0] LNS_FIXED_ADV   = 8'd9;
  localparam logic [7:0] LNS_PROLOGUE    = 8'd10;
  localparam logic [7:0] LNS_EPILOGUE    = 8'd11;
  localparam logic [7:0] LNS_SET_ISA     = 8'd12;

  localparam logic [7:0] LNE_END_SEQ     = 8'd1;
  localparam logic [7:0] LNE_SET_ADDR    = 8'd2;
  localparam logic [7:0] LNE_DISCRIM     = 8'd4;
  localparam logic [7:0] LNE_LO_USER     = 8'h80;
  localparam logic [7:0] LNE_HI_USER     = 8'hFF;

  localparam logic [1:0] KIND_ROW = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_COPY, OP_END, OP_ERR, OP_SET_ADDR, OP_ADV_LINE, OP_SET_FILE,
    OP_SET_COL, OP_FIXED_PC, OP_SPECIAL, OP_CONST_PC, OP_ADV_PC
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [AddrW-1:0] opd;
  } qent_t;

  typedef struct packed {
    logic [7:0] op_base;
    logic [7:0] ln_range;
    logic [7:0] ln_base;
    logic [7:0] min_inst;
    logic [7:0] max_ops;
    logic       addr_64;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LDIV, B_ODIV, B_OFIX, B_MUL, B_EMIT
  } bstate_t;

endpackage

/* design/dlpe_front.sv */
// Front end: classifies each instruction and holds it in a two-entry queue.
// Depends on dlpe_pkg.
`timescale 1ns / 1ps
module dlpe_front import dlpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_ext_code,
  input  logic [63:0] in_operand,
  output logic        q_valid,
  output qent_t       q_ent,
  input  logic        q_pop
);

  qent_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  qent_t      cls;
  logic       push;

  always_comb begin
    cls.op  = OP_ERR;
    cls.opd = in_operand;
    if (in_opcode == 8'd0) begin
      unique case (in_ext_code)
        LNE_END_SEQ:  cls.op = OP_END;
        LNE_SET_ADDR: cls.op = OP_SET_ADDR;
        LNE_DISCRIM, LNE_LO_USER, LNE_HI_USER: cls.op = OP_NOP;
        default:      cls.op = OP_ERR;
      endcase
    end else if (in_opcode >= cfg.op_base) begin
      cls.op  = OP_SPECIAL;
      cls.opd = {56'd0, in_opcode - cfg.op_base};
    end else begin
      unique case (in_opcode)
        LNS_COPY:       cls.op = OP_COPY;
        LNS_ADVANCE_PC: cls.op = OP_ADV_PC;
        LNS_ADVANCE_LN: cls.op = OP_ADV_LINE;
        LNS_SET_FILE:   cls.op = OP_SET_FILE;
        LNS_SET_COLUMN: cls.op = OP_SET_COL;
        LNS_NEGATE_STMT, LNS_BASIC_BLOCK, LNS_PROLOGUE, LNS_EPILOGUE,
        LNS_SET_ISA:    cls.op = OP_NOP;
        LNS_CONST_ADD: begin
          cls.op  = OP_CONST_PC;
          cls.opd = {56'd0, OpcMax - cfg.op_base};
        end
        LNS_FIXED_ADV:  cls.op = OP_FIXED_PC;
        default:        cls.op = OP_ERR;
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_ent    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

/* design/dlpe_back.sv */
// Back end: executes queued operations on the line registers with a serial
// divider and shift-add multiplier, and holds the result register.
// Depends on dlpe_pkg.
`timescale 1ns / 1ps
module dlpe_back import dlpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  qent_t       q_ent,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_file_index,
  output logic [63:0] out_address,
  output logic [31:0] out_line,
  output logic [31:0] out_column
);

  bstate_t st_r, st_nxt;

  logic [63:0] addr_r, addr_nxt;
  logic [7:0]  opi_r, opi_nxt;
  logic [31:0] file_r, file_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [7:0]  rem_r, rem_nxt, div_r, div_nxt;
  logic [8:0]  s_r, s_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        emit_r, emit_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [31:0] of_r, of_nxt, ol_r, ol_nxt, oc_r, oc_nxt;
  logic [63:0] oa_r, oa_nxt;

  logic [7:0]  eff_range, eff_ops;
  logic [31:0] lb32;
  logic [8:0]  t;
  logic        ge;
  logic [8:0]  tsub;
  logic [7:0]  rem_step;
  logic [63:0] dvd_step;
  logic        last;
  logic        slot_free;

  assign eff_range = (cfg.ln_range == 8'd0) ? 8'd1 : cfg.ln_range;
  assign eff_ops   = (cfg.max_ops == 8'd0) ? 8'd1 : cfg.max_ops;
  assign lb32      = {{24{cfg.ln_base[7]}}, cfg.ln_base};

  // one restoring division step
  assign t        = {rem_r, dvd_r[63]};
  assign ge       = (t >= {1'b0, div_r});
  assign tsub     = t - {1'b0, div_r};
  assign rem_step = ge ? tsub[7:0] : t[7:0];
  assign dvd_step = {dvd_r[62:0], ge};
  assign last     = (cnt_r == 7'd1);

  assign slot_free = !ov_r || out_ready;
  assign q_pop     = (st_r == B_IDLE) && q_valid && slot_free;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_pop) begin
          unique case (q_ent.op)
            OP_SPECIAL, OP_CONST_PC: st_nxt = B_LDIV;
            OP_ADV_PC: st_nxt = (eff_ops == 8'd1) ? B_OFIX : B_ODIV;
            default:   st_nxt = B_IDLE;
          endcase
        end
      end
      B_LDIV: if (last) st_nxt = B_ODIV;
      B_ODIV: if (last) st_nxt = B_OFIX;
      B_OFIX: if (s_r < {1'b0, div_r}) st_nxt = B_MUL;
      B_MUL:  if (cnt_r[2:0] == 3'd7) st_nxt = emit_r ? B_EMIT : B_IDLE;
      B_EMIT: if (slot_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    addr_nxt = addr_r; opi_nxt = opi_r; file_nxt = file_r;
    line_nxt = line_r; col_nxt = col_r;
    dvd_nxt = dvd_r; rem_nxt = rem_r; div_nxt = div_r; s_nxt = s_r;
    cnt_nxt = cnt_r; emit_nxt = emit_r;
    ov_nxt = ov_r && !out_ready;
    ok_nxt = ok_r; of_nxt = of_r; oa_nxt = oa_r; ol_nxt = ol_r; oc_nxt = oc_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_pop) begin
          if (q_ent.op == OP_COPY || q_ent.op == OP_END || q_ent.op == OP_ERR) begin
            ov_nxt = 1'b1;
            of_nxt = file_r; oa_nxt = addr_r; ol_nxt = line_r; oc_nxt = col_r;
            ok_nxt = (q_ent.op == OP_COPY) ? KIND_ROW :
                     (q_ent.op == OP_END)  ? KIND_END : KIND_ERR;
          end
          unique case (q_ent.op)
            OP_END: begin
              addr_nxt = '0; opi_nxt = '0; file_nxt = 32'd1;
              line_nxt = 32'd1; col_nxt = '0;
            end
            OP_SET_ADDR: begin
              addr_nxt = cfg.addr_64 ? q_ent.opd : {32'd0, q_ent.opd[31:0]};
              opi_nxt  = '0;
            end
            OP_ADV_LINE: line_nxt = line_r + q_ent.opd[31:0];
            OP_SET_FILE: file_nxt = q_ent.opd[31:0];
            OP_SET_COL:  col_nxt  = q_ent.opd[31:0];
            OP_FIXED_PC: begin
              addr_nxt = addr_r + {48'd0, q_ent.opd[15:0]};
              opi_nxt  = '0;
            end
            OP_SPECIAL, OP_CONST_PC: begin
              dvd_nxt  = {q_ent.opd[7:0], 56'd0};
              rem_nxt  = '0;
              cnt_nxt  = 7'd8;
              div_nxt  = eff_range;
              emit_nxt = (q_ent.op == OP_SPECIAL);
            end
            OP_ADV_PC: begin
              dvd_nxt  = q_ent.opd;
              rem_nxt  = '0;
              cnt_nxt  = 7'd64;
              div_nxt  = eff_ops;
              s_nxt    = {1'b0, opi_r};
              emit_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      B_LDIV: begin
        dvd_nxt = dvd_step; rem_nxt = rem_step; cnt_nxt = cnt_r - 7'd1;
        if (last) begin
          // line step from the remainder, then advance by the quotient
          if (emit_r) line_nxt = line_r + lb32 + {24'd0, rem_step};
          dvd_nxt = {dvd_step[7:0], 56'd0};
          rem_nxt = '0;
          cnt_nxt = 7'd8;
          div_nxt = eff_ops;
        end
      end
      B_ODIV: begin
        dvd_nxt = dvd_step; rem_nxt = rem_step; cnt_nxt = cnt_r - 7'd1;
        if (last) s_nxt = {1'b0, opi_r} + {1'b0, rem_step};
      end
      B_OFIX: begin
        // fold the carried operations back into the quotient
        if (s_r >= {1'b0, div_r}) begin
          s_nxt   = s_r - {1'b0, div_r};
          dvd_nxt = dvd_r + 64'd1;
        end else begin
          opi_nxt = s_r[7:0];
          cnt_nxt = '0;
        end
      end
      B_MUL: begin
        if (cfg.min_inst[cnt_r[2:0]]) addr_nxt = addr_r + (dvd_r << cnt_r[2:0]);
        cnt_nxt = cnt_r + 7'd1;
      end
      B_EMIT: begin
        if (slot_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_ROW;
          of_nxt = file_r; oa_nxt = addr_r; ol_nxt = line_r; oc_nxt = col_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; ov_r <= 1'b0;
      addr_r <= '0; opi_r <= '0; file_r <= 32'd1; line_r <= 32'd1; col_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      addr_r <= addr_nxt; opi_r <= opi_nxt; file_r <= file_nxt;
      line_r <= line_nxt; col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; div_r <= div_nxt; s_r <= s_nxt;
    cnt_r <= cnt_nxt; emit_r <= emit_nxt;
    ok_r <= ok_nxt; of_r <= of_nxt; oa_r <= oa_nxt; ol_r <= ol_nxt; oc_r <= oc_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_file_index = of_r;
  assign out_address    = oa_r;
  assign out_line       = ol_r;
  assign out_column     = oc_r;

endmodule

/* design/dwarf_line_program_engine_top.sv */
// Top level of the line program engine: configuration registers, front end
// and back end. Depends on dlpe_pkg, dlpe_front and dlpe_back.
`timescale 1ns / 1ps
// Usage:
//  - in_* carries one decoded line program instruction per request
//    (opcode, extended code, operand); accepted when in_valid && in_ready.
//  - out_* carries one row or error request; taken when out_valid && out_ready.
//  - cfg_we writes register cfg_index with cfg_wdata in the same edge;
//    write only while the engine is idle.
// Back-end work per opcode:
//  - simple opcodes: registered in the queue, then in the result register;
//    one instruction per cycle through the back end while no result stalls.
//  - special opcodes: the back end is busy for an 8-step line divide, an
//    8-step operation divide, carry fold, 8-step address multiply and
//    emit; const_add_pc runs the same steps without the emit.
//  - advance_pc: a 64-step divide when max_ops_per_inst > 1, none with a
//    single operation per instruction, then carry fold and multiply; a
//    carried operation index at or above the divisor adds fold steps.
// Reset clears the queue, the result register and returns the line
// registers to their start values; configuration returns to its defaults.
// A stalled receiver holds the result; the back end stops taking work and
// the two-entry queue fills before in_ready drops.
module dwarf_line_program_engine_top import dlpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_ext_code,
  input  logic [63:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_file_index,
  output logic [63:0] out_address,
  output logic [31:0] out_line,
  output logic [31:0] out_column,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  qent_t q_ent;

  // hold configuration; unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op_base  <= 8'd13;
      cfg_r.ln_range <= 8'd14;
      cfg_r.ln_base  <= 8'hFB;
      cfg_r.min_inst <= 8'd1;
      cfg_r.max_ops  <= 8'd1;
      cfg_r.addr_64  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OP_BASE:  cfg_r.op_base  <= cfg_wdata;
        CFG_LN_RANGE: cfg_r.ln_range <= cfg_wdata;
        CFG_LN_BASE:  cfg_r.ln_base  <= cfg_wdata;
        CFG_MIN_INST: cfg_r.min_inst <= cfg_wdata;
        CFG_MAX_OPS:  cfg_r.max_ops  <= cfg_wdata;
        CFG_ADDR_64:  cfg_r.addr_64  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dlpe_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_ready, .in_opcode, .in_ext_code, .in_operand,
    .q_valid, .q_ent, .q_pop
  );

  dlpe_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_valid, .q_ent, .q_pop,
    .out_valid, .out_ready, .out_kind, .out_file_index, .out_address,
    .out_line, .out_column
  );

endmodule

/* design/dlpe_checker.sv */
// Port-level checker for the line program engine, bound to the top level.
// Depends on assert_macros.svh and dlpe_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dlpe_checker import dlpe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_file_index,
  input logic [63:0] out_address,
  input logic [31:0] out_line,
  input logic [31:0] out_column
);

  logic [65:0] head_w;
  logic [95:0] pos_w;

  assign head_w = {out_kind, out_address};
  assign pos_w  = {out_file_index, out_line, out_column};

  `DLPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `DLPE_ASSERT(a_head_stable, out_valid && !out_ready |=> $stable(head_w))
  `DLPE_ASSERT(a_pos_stable, out_valid && !out_ready |=> $stable(pos_w))
  `DLPE_ASSERT(a_kind_legal, out_valid |-> out_kind != KIND_ERR + 2'd1)
  `DLPE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind dwarf_line_program_engine_top dlpe_checker u_chk (.*);

/* tb/dlpe_checker.sv */
// Checker for the line program engine: mirrors the configuration and line
// registers, predicts each row, end or error request and compares it. Uses dlpe_pkg.
`timescale 1ns / 1ps
module dlpe_tb_checker import dlpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_ext_code,
  input  logic [63:0] in_operand,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_file_index,
  input  logic [63:0] out_address,
  input  logic [31:0] out_line,
  input  logic [31:0] out_column,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] file;
    logic [63:0] addr;
    logic [31:0] line;
    logic [31:0] col;
  } row_t;

  row_t rows_due[$];
  cfg_t cfg;
  logic [63:0] m_addr;
  logic [7:0]  m_opi;
  logic [31:0] m_file, m_line, m_col;

  function automatic row_t snap(input logic [1:0] kind);
    row_t r;
    r.kind = kind;
    r.file = m_file;
    r.addr = m_addr;
    r.line = m_line;
    r.col  = m_col;
    return r;
  endfunction

  // Queue an expected request behind the others.
  task automatic expect_row(input logic [1:0] kind);
    rows_due.insert(rows_due.size(), snap(kind));
  endtask

  task automatic start_regs();
    m_addr = '0;
    m_opi  = '0;
    m_file = 32'd1;
    m_line = 32'd1;
    m_col  = '0;
  endtask

  // Advance address and operation index by a number of operations.
  task automatic advance_ops(input logic [63:0] adv);
    logic [63:0] m, q, r, s;
    m = (cfg.max_ops == 8'd0) ? 64'd1 : {56'd0, cfg.max_ops};
    q = adv / m;
    r = adv % m;
    s = {56'd0, m_opi} + r;
    q = q + s / m;
    m_addr = m_addr + {56'd0, cfg.min_inst} * q;
    m_opi = 8'(s % m);
  endtask

  task automatic execute(input logic [7:0] opc, input logic [7:0] ext,
                         input logic [63:0] opd);
    logic [7:0]  adj, rng;
    logic [31:0] lb;
    rng = (cfg.ln_range == 8'd0) ? 8'd1 : cfg.ln_range;
    lb  = {{24{cfg.ln_base[7]}}, cfg.ln_base};
    if (opc == 8'd0) begin
      case (ext)
        LNE_END_SEQ: begin
          expect_row(KIND_END);
          start_regs();
        end
        LNE_SET_ADDR: begin
          m_addr = cfg.addr_64 ? opd : {32'd0, opd[31:0]};
          m_opi = '0;
        end
        LNE_DISCRIM, LNE_LO_USER, LNE_HI_USER: ;
        default: expect_row(KIND_ERR);
      endcase
    end else if (opc >= cfg.op_base) begin
      adj = opc - cfg.op_base;
      m_line = m_line + lb + {24'd0, adj % rng};
      advance_ops({56'd0, adj / rng});
      expect_row(KIND_ROW);
    end else begin
      case (opc)
        LNS_COPY:       expect_row(KIND_ROW);
        LNS_ADVANCE_PC: advance_ops(opd);
        LNS_ADVANCE_LN: m_line = m_line + opd[31:0];
        LNS_SET_FILE:   m_file = opd[31:0];
        LNS_SET_COLUMN: m_col = opd[31:0];
        LNS_NEGATE_STMT, LNS_BASIC_BLOCK, LNS_PROLOGUE, LNS_EPILOGUE,
        LNS_SET_ISA: ;
        LNS_CONST_ADD: begin
          adj = OpcMax - cfg.op_base;
          advance_ops({56'd0, adj / rng});
        end
        LNS_FIXED_ADV: begin
          m_addr = m_addr + {48'd0, opd[15:0]};
          m_opi = '0;
        end
        default: expect_row(KIND_ERR);
      endcase
    end
  endtask

  task automatic compare_row();
    row_t e;
    if (rows_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected request: kind %0d addr %h", out_kind, out_address);
    end else begin
      e = rows_due.pop_front();
      if (e.kind !== out_kind || e.file !== out_file_index || e.addr !== out_address ||
          e.line !== out_line || e.col !== out_column) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: exp kind %0d file %h addr %h line %h col %h / got %0d %h %h %h %h",
                   e.kind, e.file, e.addr, e.line, e.col, out_kind, out_file_index,
                   out_address, out_line, out_column);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.op_base  = 8'd13;
      cfg.ln_range = 8'd14;
      cfg.ln_base  = 8'hFB;
      cfg.min_inst = 8'd1;
      cfg.max_ops  = 8'd1;
      cfg.addr_64  = 1'b1;
      start_regs();
      rows_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OP_BASE:  cfg.op_base = cfg_wdata;
          CFG_LN_RANGE: cfg.ln_range = cfg_wdata;
          CFG_LN_BASE:  cfg.ln_base = cfg_wdata;
          CFG_MIN_INST: cfg.min_inst = cfg_wdata;
          CFG_MAX_OPS:  cfg.max_ops = cfg_wdata;
          CFG_ADDR_64:  cfg.addr_64 = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) execute(in_opcode, in_ext_code, in_operand);
      if (out_valid && out_ready) compare_row();
    end
    pending <= rows_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the line program engine: clock, reset, request stimulus,
// configuration phases and verdict. Depends on dlpe_pkg and dlpe_tb_checker.
`timescale 1ns / 1ps
module tb_top;
  import dlpe_pkg::*;

  // Extended opcode the engine rejects; not named in the package.
  localparam logic [7:0] LNE_DEFINE_FILE = 8'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_opcode = '0;
  logic [7:0]  in_ext_code = '0;
  logic [63:0] in_operand = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_file_index;
  logic [63:0] out_address;
  logic [31:0] out_line;
  logic [31:0] out_column;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  int fail_count;
  int pending;
  int tx_pct = 34;
  int rx_pct = 47;
  logic [7:0] cur_base = 8'd13;

  always #10 clk = ~clk;

  dwarf_line_program_engine_top u_top (.*);

  dlpe_tb_checker u_chk (.*);

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  // Offer one request, idling cycle by cycle at the phase rate first, and
  // hold it until accepted.
  task automatic send(input logic [7:0] opc, input logic [7:0] ext,
                      input logic [63:0] opd);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= opc;
    in_ext_code <= ext;
    in_operand <= opd;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every row to arrive, then let up to three slow
  // advances still queued or running finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] base, input logic [7:0] rng,
                           input logic [7:0] lb, input logic [7:0] mil,
                           input logic [7:0] ops, input logic a64);
    logic [7:0] vals[6];
    vals = '{base, rng, lb, mil, ops, {7'd0, a64}};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_base = base;
    @(posedge clk);
  endtask

  // Mostly well-formed instructions with random content, some pure noise.
  task automatic send_random();
    int pick;
    logic [7:0]  opc, ext;
    logic [63:0] opd;
    pick = $urandom_range(99);
    opd = {$urandom, $urandom};
    ext = 8'($urandom);
    if (pick < 15) begin
      opc = 8'($urandom);
    end else if (pick < 55) begin
      opc = 8'($urandom_range(255, (cur_base == 8'd0) ? 1 : cur_base));
    end else if (pick < 85) begin
      opc = 8'($urandom_range(1, 12));
      if (opc == LNS_ADVANCE_PC && $urandom_range(1)) opd = 64'($urandom_range(0, 40));
      if (opc == LNS_ADVANCE_LN && $urandom_range(1))
        opd = 64'(signed'($urandom_range(0, 20)) - 10);
    end else begin
      opc = 8'd0;
      case ($urandom_range(5))
        0: ext = LNE_END_SEQ;
        1: ext = LNE_SET_ADDR;
        2: ext = LNE_DEFINE_FILE;
        3: ext = LNE_DISCRIM;
        4: ext = LNE_LO_USER;
        default: ext = LNE_HI_USER;
      endcase
    end
    send(opc, ext, opd);
  endtask

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every standard and extended opcode, field extremes.
    send(8'd0, LNE_SET_ADDR, 64'hFFFF_FFFF_FFFF_FFF0);
    send(8'd13, 8'd0, '0);
    send(8'd255, 8'hFF, '1);
    send(LNS_COPY, 8'd0, '0);
    send(LNS_ADVANCE_PC, 8'd0, '1);
    send(LNS_ADVANCE_LN, 8'd0, 64'hFFFF_FFFF_8000_0000);
    send(LNS_ADVANCE_LN, 8'd0, 64'h0000_0000_7FFF_FFFF);
    send(LNS_SET_FILE, 8'd0, '1);
    send(LNS_SET_COLUMN, 8'd0, 64'h1234_5678_FFFF_FFFF);
    send(LNS_NEGATE_STMT, 8'd0, '1);
    send(LNS_BASIC_BLOCK, 8'd0, '0);
    send(LNS_CONST_ADD, 8'd0, '0);
    send(LNS_FIXED_ADV, 8'd0, '1);
    send(LNS_PROLOGUE, 8'd0, '0);
    send(LNS_EPILOGUE, 8'd0, '0);
    send(LNS_SET_ISA, 8'd0, '1);
    send(LNS_COPY, 8'd0, '0);
    send(8'd0, LNE_DEFINE_FILE, '0);
    send(8'd0, LNE_DISCRIM, '1);
    send(8'd0, LNE_LO_USER, '0);
    send(8'd0, LNE_HI_USER, '0);
    send(8'd0, 8'd5, '0);
    send(8'd0, LNE_END_SEQ, '0);
    send(LNS_COPY, 8'd0, '0);
    drain();

    // Phases: both extremes, zero values, defaults, then random settings.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_pct = 34;
        rx_pct = 47;
      end else if (ph < 4) begin
        tx_pct = 47;
        rx_pct = 34;
      end else begin
        tx_pct = 0;
        rx_pct = 0;
      end
      case (ph)
        0: write_cfg(8'd255, 8'd255, 8'h7F, 8'd255, 8'd255, 1'b1);
        1: write_cfg(8'd1, 8'd1, 8'h80, 8'd1, 8'd1, 1'b0);
        2: write_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        3: write_cfg(8'd13, 8'd14, 8'hFB, 8'd1, 8'd1, 1'b1);
        default: write_cfg(8'($urandom_range(1, 40)), 8'($urandom_range(1, 20)),
                           8'($urandom), 8'($urandom_range(1, 8)),
                           8'($urandom_range(1, 6)), 1'($urandom));
      endcase
      for (int n = 0; n < 225; n++) send_random();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* dwarf_line_program_engine_top.f */
+incdir+design
design/dlpe_pkg.sv
design/dlpe_front.sv
design/dlpe_back.sv
design/dwarf_line_program_engine_top.sv
design/dlpe_checker.sv
tb/dlpe_checker.sv
tb/tb_top.sv
